// ===== rtl/sacl_pkg.sv =====
// ----------------------------------------------------------------------------
// sacl_pkg: shared definitions for the set-associative cache tag lookup
// Holds default sizes, register and policy codes, the lookup result struct
// and the elaboration-time tables used to reduce the LFSR value modulo WAYS.
// ----------------------------------------------------------------------------
package sacl_pkg;

	// Default sizes handed to the top level parameters.
	localparam int DEF_SETS         = 64;
	localparam int DEF_WAYS         = 4;
	localparam int DEF_ADDRESS_BITS = 32;

	// Width of the address field on the request stream.
	localparam int IN_ADDR_W = 32;

	// Widest way index that the parameter range allows (16 ways).
	localparam int WAY_IDX_MAX_W = 4;

	// Width of the reported displaced tag.
	localparam int DTAG_W = 26;

	// Victim LFSR seed.
	localparam logic [15:0] LFSR_SEED = 16'hACE1;

	// Configuration port: byte address width and register index bit.
	localparam int PADDR_W = 3;
	localparam logic REG_IDX_POLICY = 1'b0;

	// Replacement policy codes.
	localparam logic POLICY_LRU    = 1'b0;
	localparam logic POLICY_RANDOM = 1'b1;

	// Outcome of one set lookup.
	typedef struct packed {
		logic                     hit;
		logic                     displaced;
		logic                     lfsr_step;
		logic [WAY_IDX_MAX_W-1:0] way;
	} lookup_res_t;

	// A 256-entry table of 4-bit residues.
	typedef logic [255:0][3:0] mod8_tbl_t;

	// Residue of every byte value modulo w, built by a wrapping counter.
	function automatic mod8_tbl_t mod_table(input int unsigned w);
		mod8_tbl_t   t;
		int unsigned r;
		r = 0;
		for (int v = 0; v < 256; v++) begin
			t[v] = 4'(r);
			r = (r + 1 == w) ? 0 : r + 1;
		end
		return t;
	endfunction

	// Combines the residues of the high and low byte: entry {a, b} holds
	// (a * 256 + b) modulo w, given a and b already reduced.
	function automatic mod8_tbl_t fold_table(input int unsigned w);
		mod8_tbl_t   m;
		mod8_tbl_t   t;
		int unsigned c;
		m = mod_table(w);
		c = (int'(m[255]) + 1 == w) ? 0 : int'(m[255]) + 1;
		for (int a = 0; a < 16; a++) begin
			for (int b = 0; b < 16; b++) begin
				t[a * 16 + b] = m[8'(a * c + b)];
			end
		end
		return t;
	endfunction

endpackage

// ===== rtl/sacl_addr_split.sv =====
// ----------------------------------------------------------------------------
// sacl_addr_split: address to set index and tag
// For a power-of-two set count the split is a mask and a shift, registered
// once. Otherwise the tag comes from a registered reciprocal product and the
// set index from the low bits of the address minus tag times SETS.
// ----------------------------------------------------------------------------
module sacl_addr_split #(
	parameter int SETS  = 64,
	parameter int AW    = 32,
	parameter int SET_W = 6,
	parameter int TAG_W = 26
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [AW-1:0]        addr,
	output logic                 done,
	output logic [SET_W-1:0]     set_idx,
	output logic [TAG_W-1:0]     tag
);
	localparam int LOG_S = $clog2(SETS);

	if ((SETS & (SETS - 1)) == 0) begin : g_pow2
		logic             done_q;
		logic [SET_W-1:0] set_q;
		logic [TAG_W-1:0] tag_q;

		// Done is the start pulse delayed by one register.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				done_q <= 1'b0;
			end else begin
				done_q <= start;
			end
		end

		// The low bits pick the set, the rest form the tag.
		always_ff @(posedge clk) begin
			if (start) begin
				set_q <= SET_W'(addr & AW'(SETS - 1));
				tag_q <= TAG_W'(addr >> LOG_S);
			end
		end

		assign done    = done_q;
		assign set_idx = set_q;
		assign tag     = tag_q;
	end else begin : g_recip
		// Rounded-up reciprocal of SETS scaled by 2^(AW+LOG_S); exact for
		// every AW-bit dividend.
		localparam int MUL_SH = AW + LOG_S;
		localparam int MUL_W  = AW + 1;
		localparam int PROD_W = AW + MUL_W;
		localparam logic [MUL_W-1:0] MULT =
			MUL_W'(((64'd1 << MUL_SH) + 64'(SETS) - 64'd1) / 64'(SETS));
		localparam logic [SET_W-1:0] SETS_LO = SET_W'(SETS);

		logic              v_s1;
		logic              done_q;
		logic [PROD_W-1:0] prod_s1;
		logic [SET_W-1:0]  addr_lo_s1;
		logic [SET_W-1:0]  set_q;
		logic [TAG_W-1:0]  tag_q;
		logic [TAG_W-1:0]  quot;
		logic [SET_W-1:0]  quot_lo;
		logic [SET_W-1:0]  quot_mul;

		// Quotient from the top of the product; the remainder only needs
		// its low bits since it is below SETS.
		assign quot     = TAG_W'(prod_s1 >> MUL_SH);
		assign quot_lo  = SET_W'(quot);
		assign quot_mul = quot_lo * SETS_LO;

		// Stage valid and done pulse.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1   <= 1'b0;
				done_q <= 1'b0;
			end else begin
				v_s1   <= start;
				done_q <= v_s1;
			end
		end

		// Multiply on start, then quotient and remainder from the registered product.
		always_ff @(posedge clk) begin
			if (start) begin
				prod_s1    <= PROD_W'(addr) * PROD_W'(MULT);
				addr_lo_s1 <= SET_W'(addr);
			end
			if (v_s1) begin
				tag_q <= quot;
				set_q <= addr_lo_s1 - quot_mul;
			end
		end

		assign done    = done_q;
		assign set_idx = set_q;
		assign tag     = tag_q;
	end

endmodule

// ===== rtl/sacl_set_store.sv =====
// ----------------------------------------------------------------------------
// sacl_set_store: per-set state and tag memories
// Two synchronous memories indexed by set: one row of valid bits and recency
// ranks, and one row of tags. One read port with registered data and one
// write port shared by both.
// ----------------------------------------------------------------------------
module sacl_set_store #(
	parameter int SETS  = 64,
	parameter int WAYS  = 4,
	parameter int RW    = 2,
	parameter int TAG_W = 26,
	parameter int SET_W = 6
) (
	input  logic                    clk,
	input  logic                    rd_en,
	input  logic [SET_W-1:0]        rd_addr,
	input  logic [SET_W-1:0]        wr_addr,
	input  logic                    st_we,
	input  logic [WAYS-1:0]         st_wvalid,
	input  logic [WAYS*RW-1:0]      st_wranks,
	input  logic                    tg_we,
	input  logic [WAYS*TAG_W-1:0]   tg_wdata,
	output logic [WAYS-1:0]         rd_valid,
	output logic [WAYS*RW-1:0]      rd_ranks,
	output logic [WAYS*TAG_W-1:0]   rd_tags
);
	localparam int ST_ROW_W = WAYS + WAYS * RW;

	logic [ST_ROW_W-1:0]   st_mem [SETS];
	logic [WAYS*TAG_W-1:0] tg_mem [SETS];
	logic [ST_ROW_W-1:0]   st_rd_q;
	logic [WAYS*TAG_W-1:0] tg_rd_q;

	// State row: valid bits above the ranks.
	always_ff @(posedge clk) begin
		if (st_we) begin
			st_mem[wr_addr] <= {st_wvalid, st_wranks};
		end
		if (rd_en) begin
			st_rd_q <= st_mem[rd_addr];
		end
	end

	// Tag row.
	always_ff @(posedge clk) begin
		if (tg_we) begin
			tg_mem[wr_addr] <= tg_wdata;
		end
		if (rd_en) begin
			tg_rd_q <= tg_mem[rd_addr];
		end
	end

	assign rd_valid = st_rd_q[ST_ROW_W-1 -: WAYS];
	assign rd_ranks = st_rd_q[WAYS*RW-1:0];
	assign rd_tags  = tg_rd_q;

endmodule

// ===== rtl/sacl_way_select.sv =====
// ----------------------------------------------------------------------------
// sacl_way_select: tag compare, victim choice and row update
// Compares all ways of the read set against the request tag, picks the way
// to use (hit, first invalid, least recently used or random) and builds the
// updated valid, rank and tag rows for write-back.
// ----------------------------------------------------------------------------
module sacl_way_select #(
	parameter int WAYS  = 4,
	parameter int RW    = 2,
	parameter int TAG_W = 26
) (
	input  logic [WAYS-1:0]               valid,
	input  logic [WAYS*RW-1:0]            ranks,
	input  logic [WAYS*TAG_W-1:0]         tags,
	input  logic [TAG_W-1:0]              tag,
	input  logic                          policy,
	input  logic [15:0]                   lfsr_next,
	output sacl_pkg::lookup_res_t         res,
	output logic [TAG_W-1:0]              victim_tag,
	output logic [WAYS-1:0]               new_valid,
	output logic [WAYS*RW-1:0]            new_ranks,
	output logic [WAYS*TAG_W-1:0]         new_tags
);
	import sacl_pkg::*;

	localparam mod8_tbl_t MOD_TBL  = mod_table(WAYS);
	localparam mod8_tbl_t FOLD_TBL = fold_table(WAYS);

	logic          hit;
	logic [RW-1:0] hit_way;
	logic          any_inv;
	logic [RW-1:0] inv_way;
	logic          lru_found;
	logic [RW-1:0] lru_way;
	logic [RW-1:0] rnd_way;
	logic [RW-1:0] found;
	logic          full_miss;
	logic [RW-1:0] found_rank;

	// Random way: LFSR value modulo WAYS from its two bytes.
	assign rnd_way = RW'(FOLD_TBL[{MOD_TBL[lfsr_next[15:8]], MOD_TBL[lfsr_next[7:0]]}]);

	// Priority searches over the ways of the set.
	always_comb begin
		hit       = 1'b0;
		hit_way   = '0;
		any_inv   = 1'b0;
		inv_way   = '0;
		lru_found = 1'b0;
		lru_way   = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (!hit && valid[w] && tags[w*TAG_W +: TAG_W] == tag) begin
				hit     = 1'b1;
				hit_way = RW'(w);
			end
			if (!any_inv && !valid[w]) begin
				any_inv = 1'b1;
				inv_way = RW'(w);
			end
			if (!lru_found && ranks[w*RW +: RW] == RW'(WAYS - 1)) begin
				lru_found = 1'b1;
				lru_way   = RW'(w);
			end
		end
	end

	// Way chosen for this request.
	assign full_miss = !hit && !any_inv;
	always_comb begin
		if (hit) begin
			found = hit_way;
		end else if (any_inv) begin
			found = inv_way;
		end else if (policy == POLICY_RANDOM) begin
			found = rnd_way;
		end else begin
			found = lru_way;
		end
	end

	// Rank and old tag of the chosen way.
	always_comb begin
		found_rank = '0;
		victim_tag = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (RW'(w) == found) begin
				found_rank = ranks[w*RW +: RW];
				victim_tag = tags[w*TAG_W +: TAG_W];
			end
		end
	end

	// Updated rows: chosen way becomes most recent, younger ways age by one.
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			new_valid[w] = valid[w] | (RW'(w) == found);
			if (RW'(w) == found) begin
				new_ranks[w*RW +: RW] = '0;
			end else if (ranks[w*RW +: RW] < found_rank) begin
				new_ranks[w*RW +: RW] = ranks[w*RW +: RW] + 1'b1;
			end else begin
				new_ranks[w*RW +: RW] = ranks[w*RW +: RW];
			end
			if (!hit && RW'(w) == found) begin
				new_tags[w*TAG_W +: TAG_W] = tag;
			end else begin
				new_tags[w*TAG_W +: TAG_W] = tags[w*TAG_W +: TAG_W];
			end
		end
	end

	assign res.hit       = hit;
	assign res.displaced = full_miss;
	assign res.lfsr_step = full_miss && (policy == POLICY_RANDOM);
	assign res.way       = WAY_IDX_MAX_W'(found);

endmodule

// ===== rtl/set_assoc_cache_tag_lookup.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup: tag store of a set-associative cache
// Looks up one address per request, updates valid bits, recency ranks and
// tags of the selected set, and reports hit, way and any displaced line.
//
//   Channel   Direction  Signals                  Content
//   s_*       in         tvalid tready tdata[31:0] address
//   m_*       out        tvalid tready tdata[31:0] hit, way_used, displaced,
//                                                   displaced_tag
//   APB       in/out     psel penable pwrite paddr  replacement_policy (0x0)
//                        pwdata prdata pready
//
// A request passes through the address split, the set memory read and the
// compare and write-back; with a SETS that is not a power of two the split
// first registers a reciprocal multiply for set and tag.
// After reset a clearing pass writes every state row; no request is accepted
// during it. A result waiting on m_tready holds the lookup stage only when a
// second result is ready behind it.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lookup #(
	parameter int SETS         = sacl_pkg::DEF_SETS,
	parameter int WAYS         = sacl_pkg::DEF_WAYS,
	parameter int ADDRESS_BITS = sacl_pkg::DEF_ADDRESS_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Request stream.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [31:0]                   s_tdata,   // [31:0] address
	// Result stream.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [31:0]                   m_tdata,   // [0] hit, [2:1] way_used,
	                                                 // [3] displaced,
	                                                 // [29:4] displaced_tag, [31:30] 0
	// Configuration port.
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sacl_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import sacl_pkg::*;

	localparam int AW        = (ADDRESS_BITS < IN_ADDR_W) ? ADDRESS_BITS : IN_ADDR_W;
	localparam int LOG_S     = $clog2(SETS);
	localparam int SET_W     = (LOG_S > 0) ? LOG_S : 1;
	localparam int FLOOR_LOG = $clog2(SETS + 1) - 1;
	localparam int TAG_W     = (AW > FLOOR_LOG) ? AW - FLOOR_LOG : 1;
	localparam int RW        = (WAYS > 1) ? $clog2(WAYS) : 1;

	typedef enum logic [3:0] {
		ST_CLEAR  = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_SPLIT  = 4'b0100,
		ST_LOOKUP = 4'b1000
	} state_t;

	state_t                state_q;
	logic [SET_W-1:0]      clr_q;
	logic [SET_W-1:0]      set_q;
	logic [TAG_W-1:0]      tag_q;
	logic                  policy_q;
	logic [15:0]           lfsr_q;
	logic [15:0]           lfsr_next;
	logic                  m_tvalid_q;
	logic [31:0]           m_tdata_q;

	logic                  accept;
	logic                  split_done;
	logic [SET_W-1:0]      split_set;
	logic [TAG_W-1:0]      split_tag;
	logic                  rd_en;
	logic                  commit;
	logic                  cfg_wr;
	logic                  reg_idx;

	logic [WAYS-1:0]       rd_valid;
	logic [WAYS*RW-1:0]    rd_ranks;
	logic [WAYS*TAG_W-1:0] rd_tags;
	logic [WAYS-1:0]       new_valid;
	logic [WAYS*RW-1:0]    new_ranks;
	logic [WAYS*TAG_W-1:0] new_tags;
	logic [WAYS*RW-1:0]    rank_init;
	logic [WAYS-1:0]       st_wvalid;
	logic [WAYS*RW-1:0]    st_wranks;
	logic [SET_W-1:0]      wr_addr;
	logic [TAG_W-1:0]      victim_tag;
	lookup_res_t           res;

	// Reset ranks: each way starts at its own index.
	for (genvar w = 0; w < WAYS; w++) begin : g_rank_init
		assign rank_init[w*RW +: RW] = RW'(w);
	end

	// Handshakes and control strobes.
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign rd_en     = (state_q == ST_SPLIT) && split_done;
	assign commit    = (state_q == ST_LOOKUP) && (!m_tvalid_q || m_tready);
	assign lfsr_next = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};

	// Write port: clearing pass or write-back of the looked-up set.
	assign wr_addr   = (state_q == ST_CLEAR) ? clr_q : set_q;
	assign st_wvalid = (state_q == ST_CLEAR) ? '0 : new_valid;
	assign st_wranks = (state_q == ST_CLEAR) ? rank_init : new_ranks;

	// Configuration register access.
	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = (reg_idx == REG_IDX_POLICY) ? 32'(policy_q) : '0;

	sacl_addr_split #(
		.SETS  (SETS),
		.AW    (AW),
		.SET_W (SET_W),
		.TAG_W (TAG_W)
	) u_split (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.addr    (s_tdata[AW-1:0]),
		.done    (split_done),
		.set_idx (split_set),
		.tag     (split_tag)
	);

	sacl_set_store #(
		.SETS  (SETS),
		.WAYS  (WAYS),
		.RW    (RW),
		.TAG_W (TAG_W),
		.SET_W (SET_W)
	) u_store (
		.clk       (clk),
		.rd_en     (rd_en),
		.rd_addr   (split_set),
		.wr_addr   (wr_addr),
		.st_we     ((state_q == ST_CLEAR) || commit),
		.st_wvalid (st_wvalid),
		.st_wranks (st_wranks),
		.tg_we     (commit && !res.hit),
		.tg_wdata  (new_tags),
		.rd_valid  (rd_valid),
		.rd_ranks  (rd_ranks),
		.rd_tags   (rd_tags)
	);

	sacl_way_select #(
		.WAYS  (WAYS),
		.RW    (RW),
		.TAG_W (TAG_W)
	) u_select (
		.valid      (rd_valid),
		.ranks      (rd_ranks),
		.tags       (rd_tags),
		.tag        (tag_q),
		.policy     (policy_q),
		.lfsr_next  (lfsr_next),
		.res        (res),
		.victim_tag (victim_tag),
		.new_valid  (new_valid),
		.new_ranks  (new_ranks),
		.new_tags   (new_tags)
	);

	// Sequencer, LFSR, policy register and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			lfsr_q     <= LFSR_SEED;
			policy_q   <= POLICY_LRU;
			m_tvalid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (clr_q == SET_W'(SETS - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SPLIT;
					end
				end
				ST_SPLIT: begin
					if (split_done) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
			if (commit && res.lfsr_step) begin
				lfsr_q <= lfsr_next;
			end
			if (cfg_wr && reg_idx == REG_IDX_POLICY) begin
				policy_q <= pwdata[0];
			end
			if (commit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Request set and tag held for the lookup and write-back.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			set_q <= split_set;
			tag_q <= split_tag;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (commit) begin
			m_tdata_q <= {2'b00,
			              res.displaced ? DTAG_W'(victim_tag) : DTAG_W'(0),
			              res.displaced,
			              res.way[1:0],
			              res.hit};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== rtl/sacl_checker.sv =====
// ----------------------------------------------------------------------------
// sacl_checker: port-level checks for the cache tag lookup
// Watches the request and result streams and checks result encoding and
// the one-request-at-a-time sequencing.
// ----------------------------------------------------------------------------
module sacl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// A stalled result keeps its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// A hit never displaces a line.
	a_hit_no_disp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[3]))
		else $error("hit reported together with displacement");

	// The displaced tag is zero when nothing was displaced.
	a_dtag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[3] |-> m_tdata[29:4] == 26'd0)
		else $error("displaced tag set without displacement");

	// Padding bits stay zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:30] == 2'b00)
		else $error("padding bits of result not zero");

	// After a request is taken, the next is not taken in the following cycle.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while lookup in progress");

endmodule

bind set_assoc_cache_tag_lookup sacl_checker u_sacl_checker (.*);

// ===== tb/sv/set_assoc_cache_tag_lookup_tb.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup_tb: self-checking bench for the cache tag lookup
// Drives addresses on the request stream and predicts hit, way, displacement
// and the displaced tag with a behavioural copy of the tag store, its recency
// ranks and its victim LFSR. A short directed table is followed by random
// phases under both replacement policies and several idling patterns.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lookup_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sacl_pkg::*;

	localparam int SETS         = DEF_SETS;
	localparam int WAYS         = DEF_WAYS;
	localparam int ADDRESS_BITS = DEF_ADDRESS_BITS;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 150;
	localparam int DIR_ROWS     = 21;
	localparam logic [PADDR_W-1:0] POLICY_ADDR = PADDR_W'(4 * int'(REG_IDX_POLICY));

	// Fields of one lookup result.
	typedef struct packed {
		logic                hit;
		logic [1:0]          way_used;
		logic                displaced;
		logic [DTAG_W-1:0]   displaced_tag;
	} lookup_t;

	// One row of the directed table; typed rows carry their own expectation.
	typedef struct packed {
		logic [31:0] addr;
		logic        policy;
		logic        typed;
		lookup_t     want;
	} directed_row_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	// Shadow copy of the tag store.
	bit          shadow_valid [SETS][WAYS];
	logic [31:0] shadow_tag   [SETS][WAYS];
	int          shadow_rank  [SETS][WAYS];
	logic [15:0] shadow_lfsr;
	logic        policy_q;

	lookup_t     pending_lookups [$];
	int          mismatch_count = 0;
	int          cycle_count    = 0;
	int          send_gap_pct   = 0;
	int          recv_stall_pct = 0;
	logic [25:0] hot_tag_base   = '0;
	logic [31:0] recent_addr [8];
	int          recent_wr      = 0;

	directed_row_t directed_rows [DIR_ROWS] = '{
		'{32'h0000_0000, POLICY_LRU,    1'b1, '{1'b0, 2'd0, 1'b0, 26'd0}},
		'{32'hFFFF_FFFF, POLICY_LRU,    1'b1, '{1'b0, 2'd0, 1'b0, 26'd0}},
		'{32'h0000_0040, POLICY_LRU,    1'b1, '{1'b0, 2'd1, 1'b0, 26'd0}},
		'{32'h0000_0080, POLICY_LRU,    1'b1, '{1'b0, 2'd2, 1'b0, 26'd0}},
		'{32'h0000_00C0, POLICY_LRU,    1'b1, '{1'b0, 2'd3, 1'b0, 26'd0}},
		'{32'h0000_0000, POLICY_LRU,    1'b1, '{1'b1, 2'd0, 1'b0, 26'd0}},
		'{32'h0000_0100, POLICY_LRU,    1'b1, '{1'b0, 2'd1, 1'b1, 26'd1}},
		'{32'hFFFF_FFC0, POLICY_LRU,    1'b0, '0},
		'{32'hFFFF_FFC0, POLICY_LRU,    1'b0, '0},
		'{32'h0000_003F, POLICY_LRU,    1'b0, '0},
		'{32'hFFFF_FFFF, POLICY_LRU,    1'b1, '{1'b1, 2'd0, 1'b0, 26'd0}},
		'{32'hAAAA_AAAA, POLICY_LRU,    1'b0, '0},
		'{32'h5555_5555, POLICY_LRU,    1'b0, '0},
		'{32'h8000_0000, POLICY_LRU,    1'b0, '0},
		'{32'h0000_0140, POLICY_RANDOM, 1'b0, '0},
		'{32'h0000_0180, POLICY_RANDOM, 1'b0, '0},
		'{32'h0000_01C0, POLICY_RANDOM, 1'b0, '0},
		'{32'h0000_0200, POLICY_RANDOM, 1'b0, '0},
		'{32'h0000_0240, POLICY_RANDOM, 1'b0, '0},
		'{32'h0000_0000, POLICY_RANDOM, 1'b0, '0},
		'{32'h7FFF_FFFF, POLICY_RANDOM, 1'b0, '0}
	};

	set_assoc_cache_tag_lookup #(
		.SETS         (SETS),
		.WAYS         (WAYS),
		.ADDRESS_BITS (ADDRESS_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [31:0] address
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [0] hit, [2:1] way_used, [3] displaced, [29:4] displaced_tag
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// 20 ns clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: run limit reached with %0d requests outstanding", $time,
				pending_lookups.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Result side back-pressure.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		lookup_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_lookups.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %08h", $time, m_tdata);
				mismatch_count++;
			end else begin
				want = pending_lookups.pop_front();
				if (m_tdata[0] !== want.hit) begin
					$display("%0t: hit expected %0h actual %0h", $time, want.hit, m_tdata[0]);
					mismatch_count++;
				end
				if (m_tdata[2:1] !== want.way_used) begin
					$display("%0t: way_used expected %0h actual %0h", $time, want.way_used,
						m_tdata[2:1]);
					mismatch_count++;
				end
				if (m_tdata[3] !== want.displaced) begin
					$display("%0t: displaced expected %0h actual %0h", $time, want.displaced,
						m_tdata[3]);
					mismatch_count++;
				end
				if (m_tdata[29:4] !== want.displaced_tag) begin
					$display("%0t: displaced_tag expected %07h actual %07h", $time,
						want.displaced_tag, m_tdata[29:4]);
					mismatch_count++;
				end
			end
		end
	end

	// Behavioural lookup: updates the shadow store and returns the result.
	function automatic lookup_t predict_lookup(input logic [31:0] addr);
		int          set_idx;
		logic [31:0] tag;
		int          way;
		int          old_rank;
		lookup_t     res;
		set_idx = int'(addr % 32'(SETS));
		tag     = addr / 32'(SETS);
		res     = '0;
		way     = -1;
		for (int w = 0; w < WAYS; w++) begin
			if (way < 0 && shadow_valid[set_idx][w] && shadow_tag[set_idx][w] == tag)
				way = w;
		end
		if (way >= 0) begin
			res.hit = 1'b1;
		end else begin
			// Fill the lowest invalid way first.
			for (int w = 0; w < WAYS; w++) begin
				if (way < 0 && !shadow_valid[set_idx][w])
					way = w;
			end
			// Full set: evict by policy.
			if (way < 0) begin
				if (policy_q == POLICY_LRU) begin
					way = 0;
					for (int w = WAYS - 1; w >= 0; w--) begin
						if (shadow_rank[set_idx][w] == WAYS - 1)
							way = w;
					end
				end else begin
					shadow_lfsr = {shadow_lfsr[0] ^ shadow_lfsr[2] ^ shadow_lfsr[3] ^
						shadow_lfsr[5], shadow_lfsr[15:1]};
					way = int'(shadow_lfsr % 16'(WAYS));
				end
				res.displaced     = 1'b1;
				res.displaced_tag = shadow_tag[set_idx][way][DTAG_W-1:0];
			end
			shadow_valid[set_idx][way] = 1'b1;
			shadow_tag[set_idx][way]   = tag;
		end
		// The touched way becomes most recent; younger ways age by one.
		old_rank = shadow_rank[set_idx][way];
		for (int w = 0; w < WAYS; w++) begin
			if (shadow_rank[set_idx][w] < old_rank)
				shadow_rank[set_idx][w]++;
		end
		shadow_rank[set_idx][way] = 0;
		res.way_used = 2'(way);
		return res;
	endfunction

	// Offers one request and waits for it to be taken. Called at a clock edge.
	task automatic send_address(input logic [31:0] addr, input logic typed,
		input lookup_t want);
		int      gap;
		lookup_t predicted;
		gap = 0;
		while (gap < 40 && $urandom_range(0, 99) < send_gap_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= addr;
		do
			@(posedge clk);
		while (!s_tready);
		predicted = predict_lookup(addr);
		pending_lookups.push_back(typed ? want : predicted);
		recent_addr[recent_wr] = addr;
		recent_wr = (recent_wr + 1) % 8;
	endtask

	// Holds the request side idle until every expected result has arrived.
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (pending_lookups.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Register write: setup phase, then access phase.
	task automatic write_policy(input logic policy);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= POLICY_ADDR;
		pwdata  <= {31'd0, policy};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		policy_q = policy;
	endtask

	// Mostly a few hot sets with a small tag pool, so hits and evictions are
	// frequent; the rest are repeats and fully random addresses.
	function automatic logic [31:0] pick_address();
		int          sel;
		logic [25:0] tag;
		int          set_idx;
		sel = $urandom_range(0, 99);
		if (sel < 12)
			return $urandom();
		if (sel < 25)
			return recent_addr[$urandom_range(0, 7)];
		tag     = hot_tag_base ^ 26'($urandom_range(0, 5));
		set_idx = (sel < 30) ? $urandom_range(0, SETS - 1) : $urandom_range(0, 3);
		return 32'(tag) * 32'(SETS) + 32'(set_idx);
	endfunction

	initial begin
		for (int s = 0; s < SETS; s++) begin
			for (int w = 0; w < WAYS; w++) begin
				shadow_valid[s][w] = 1'b0;
				shadow_tag[s][w]   = '0;
				shadow_rank[s][w]  = w;
			end
		end
		for (int i = 0; i < 8; i++)
			recent_addr[i] = '0;
		shadow_lfsr = LFSR_SEED;
		policy_q    = POLICY_LRU;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table; the policy is changed only with the block idle.
		for (int r = 0; r < DIR_ROWS; r++) begin
			if (directed_rows[r].policy != policy_q) begin
				wait_for_results();
				write_policy(directed_rows[r].policy);
			end
			send_address(directed_rows[r].addr, directed_rows[r].typed,
				directed_rows[r].want);
		end

		// Random phases: each idling pattern under each policy.
		for (int p = 0; p < PHASES; p++) begin
			wait_for_results();
			write_policy((p >= PHASES / 2) ? POLICY_RANDOM : POLICY_LRU);
			case (p % 4)
				0: begin
					send_gap_pct   = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_gap_pct   = 52;
					recv_stall_pct = 0;
				end
				2: begin
					send_gap_pct   = 0;
					recv_stall_pct = 52;
				end
				default: begin
					send_gap_pct   = 15;
					recv_stall_pct = 15;
				end
			endcase
			hot_tag_base = 26'($urandom());
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// Let the pipeline run dry once in the middle of a phase.
				if (p == 3 && i == PHASE_ITEMS / 2)
					wait_for_results();
				send_address(pick_address(), 1'b0, '0);
			end
		end

		wait_for_results();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
